[design/lpp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared types, the fixed type table and decode helpers for the LPP record
// stream parser.
// ----------------------------------------------------------------------------
package lpp_pkg;

   // Type table dimensions.
   localparam int NUM_TYPES  = 38;
   localparam int TYPE_IDX_W = $clog2(NUM_TYPES);

   // Type codes with a value made of several components or a fixed sign rule.
   localparam logic [7:0] T_ACCEL  = 8'd113;
   localparam logic [7:0] T_GYRO   = 8'd134;
   localparam logic [7:0] T_GPS4   = 8'd136;
   localparam logic [7:0] T_GPS6   = 8'd137;
   localparam logic [7:0] T_COLOUR = 8'd135;
   localparam logic [7:0] T_NODE   = 8'd255;

   // Known type codes, in table order.
   localparam logic [7:0] TYPE_IDS [NUM_TYPES] = '{
      8'd0,   8'd1,   8'd2,   8'd3,   8'd100, 8'd101, 8'd102, 8'd103,
      8'd104, 8'd112, 8'd113, 8'd115, 8'd116, 8'd117, 8'd118, 8'd120,
      8'd121, 8'd125, 8'd128, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134,
      8'd135, 8'd136, 8'd137, 8'd138, 8'd142, 8'd188, 8'd190, 8'd191,
      8'd192, 8'd193, 8'd194, 8'd195, 8'd203, 8'd255};

   // Value length in bytes of each known type.
   localparam logic [3:0] TYPE_SIZES [NUM_TYPES] = '{
      4'd1, 4'd1, 4'd2, 4'd2, 4'd4, 4'd2, 4'd1, 4'd2,
      4'd1, 4'd2, 4'd6, 4'd2, 4'd2, 4'd2, 4'd4, 4'd1,
      4'd2, 4'd2, 4'd2, 4'd4, 4'd4, 4'd2, 4'd4, 4'd6,
      4'd3, 4'd9, 4'd11, 4'd2, 4'd1, 4'd2, 4'd2, 4'd2,
      4'd2, 4'd2, 4'd2, 4'd2, 4'd1, 4'd4};

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_VALUE   = 2'd0,
      STATUS_UNKNOWN = 2'd1,
      STATUS_TRUNC   = 2'd2
   } lpp_status_type;

   // One result item.
   typedef struct packed {
      logic           valid;
      logic [7:0]     channel;
      logic [7:0]     type_code;
      logic [1:0]     component;
      logic [32:0]    raw_value;
      lpp_status_type status;
      logic           last;
   } lpp_result_type;

   // Type code held at a table index; zero past the end of the table.
   function automatic logic [7:0] code_of(logic [TYPE_IDX_W-1:0] idx);
      logic [7:0] code;
      if (idx < NUM_TYPES) begin
         code = TYPE_IDS[idx];
      end else begin
         code = 8'd0;
      end
      return code;
   endfunction

   // Number of components in a value of the given type.
   function automatic logic [1:0] num_comp(logic [7:0] code);
      logic [1:0] n;
      if (code == T_ACCEL || code == T_GYRO || code == T_GPS4 || code == T_GPS6 ||
          code == T_COLOUR) begin
         n = 2'd3;
      end else begin
         n = 2'd1;
      end
      return n;
   endfunction

   // Byte length of one component.
   function automatic logic [2:0] comp_len(logic [TYPE_IDX_W-1:0] idx, logic [1:0] comp);
      logic [7:0] code;
      logic [2:0] len;
      code = code_of(idx);
      if (code == T_ACCEL || code == T_GYRO) begin
         len = 3'd2;
      end else if (code == T_GPS4) begin
         len = 3'd3;
      end else if (code == T_GPS6) begin
         len = (comp < 2'd2) ? 3'd4 : 3'd3;
      end else if (code == T_COLOUR) begin
         len = 3'd1;
      end else if (idx < NUM_TYPES) begin
         len = TYPE_SIZES[idx][2:0];
      end else begin
         len = 3'd1;
      end
      return len;
   endfunction

   // Whether a component is read as two's complement.
   function automatic logic comp_signed(logic [7:0] code, logic [2:0] len);
      logic sgn;
      if (code == T_ACCEL || code == T_GYRO || code == T_GPS4 || code == T_GPS6) begin
         sgn = 1'b1;
      end else if (code == T_COLOUR || code == T_NODE) begin
         sgn = 1'b0;
      end else begin
         sgn = (len == 3'd4);
      end
      return sgn;
   endfunction

   // Keep the low len bytes of the assembly word and extend them to 33 bits.
   function automatic logic [32:0] extend_value(logic [31:0] v, logic [2:0] len, logic sgn);
      logic [32:0] x;
      case (len)
         3'd1: begin
            x = {{25{sgn & v[7]}}, v[7:0]};
         end
         3'd2: begin
            x = {{17{sgn & v[15]}}, v[15:0]};
         end
         3'd3: begin
            x = {{9{sgn & v[23]}}, v[23:0]};
         end
         3'd4: begin
            x = {sgn & v[31], v};
         end
         default: begin
            x = {1'b0, v};
         end
      endcase
      return x;
   endfunction

endpackage
`default_nettype wire

[design/lpp_type_match.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpp_type_match
// Looks a received type byte up in the fixed type table and returns its index.
// ----------------------------------------------------------------------------
module lpp_type_match
   import lpp_pkg::*;
(
   input  wire logic [7:0]            code,
   output      logic                  hit,
   output      logic [TYPE_IDX_W-1:0] index
);

   // Compare against every table entry; the lowest matching entry wins.
   always_comb begin
      hit   = 1'b0;
      index = '0;
      for (int i = NUM_TYPES - 1; i >= 0; i--) begin
         if (TYPE_IDS[i] == code) begin
            hit   = 1'b1;
            index = TYPE_IDX_W'(i);
         end
      end
   end

endmodule
`default_nettype wire

[design/lpp_parse_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpp_parse_core
// Record parse state and the per-byte decode that forms the next result.
// ----------------------------------------------------------------------------
module lpp_parse_core
   import lpp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           fire,
   input  wire logic [7:0]     data_byte,
   input  wire logic           end_of_packet,
   output      lpp_result_type result
);

   typedef enum logic [3:0] {
      PH_CHAN  = 4'b0001,
      PH_TYPE  = 4'b0010,
      PH_VALUE = 4'b0100,
      PH_DROP  = 4'b1000
   } lpp_phase_type;

   lpp_phase_type         phase_ff, phase_in;
   logic [7:0]            channel_ff, channel_in;
   logic [TYPE_IDX_W-1:0] type_index_ff, type_index_in;
   logic [1:0]            comp_ff, comp_in;
   logic [2:0]            bytes_left_ff, bytes_left_in;
   logic [31:0]           acc_ff, acc_in;

   logic                  type_hit;
   logic [TYPE_IDX_W-1:0] type_found;

   logic [7:0]            cur_code;
   logic [2:0]            cur_len;
   logic [1:0]            cur_ncomp;
   logic [31:0]           acc_shift;
   logic [2:0]            bytes_dec;
   logic [2:0]            comp_next;
   logic                  record_done;
   lpp_result_type        res;

   lpp_type_match u_type_match (
      .code  (data_byte),
      .hit   (type_hit),
      .index (type_found)
   );

   // Values that the value phase works from.
   always_comb begin
      cur_code    = code_of(type_index_ff);
      cur_len     = comp_len(type_index_ff, comp_ff);
      cur_ncomp   = num_comp(cur_code);
      acc_shift   = {acc_ff[23:0], data_byte};
      bytes_dec   = (bytes_left_ff != 3'd0) ? (bytes_left_ff - 3'd1) : 3'd0;
      comp_next   = {1'b0, comp_ff} + 3'd1;
      record_done = (comp_next >= {1'b0, cur_ncomp});
   end

   // Next state and result for the byte at hand.
   always_comb begin
      phase_in      = phase_ff;
      channel_in    = channel_ff;
      type_index_in = type_index_ff;
      comp_in       = comp_ff;
      bytes_left_in = bytes_left_ff;
      acc_in        = acc_ff;
      res           = '0;
      case (phase_ff)
         PH_CHAN: begin
            if (end_of_packet) begin
               res.valid   = 1'b1;
               res.channel = data_byte;
               res.status  = STATUS_TRUNC;
               res.last    = 1'b1;
            end else begin
               channel_in = data_byte;
               phase_in   = PH_TYPE;
            end
         end
         PH_TYPE: begin
            if (!type_hit) begin
               res.valid     = 1'b1;
               res.channel   = channel_ff;
               res.type_code = data_byte;
               res.status    = STATUS_UNKNOWN;
               res.last      = end_of_packet;
               phase_in      = end_of_packet ? PH_CHAN : PH_DROP;
            end else begin
               type_index_in = type_found;
               comp_in       = 2'd0;
               acc_in        = '0;
               bytes_left_in = comp_len(type_found, 2'd0);
               if (end_of_packet) begin
                  res.valid     = 1'b1;
                  res.channel   = channel_ff;
                  res.type_code = data_byte;
                  res.status    = STATUS_TRUNC;
                  res.last      = 1'b1;
                  phase_in      = PH_CHAN;
               end else begin
                  phase_in = PH_VALUE;
               end
            end
         end
         PH_VALUE: begin
            acc_in        = acc_shift;
            bytes_left_in = bytes_dec;
            if (bytes_dec != 3'd0) begin
               // Component still incomplete.
               if (end_of_packet) begin
                  res.valid     = 1'b1;
                  res.channel   = channel_ff;
                  res.type_code = cur_code;
                  res.component = comp_ff;
                  res.status    = STATUS_TRUNC;
                  res.last      = 1'b1;
                  phase_in      = PH_CHAN;
               end
            end else if (end_of_packet && !record_done) begin
               // Component done but the record is cut short.
               res.valid     = 1'b1;
               res.channel   = channel_ff;
               res.type_code = cur_code;
               res.component = comp_ff;
               res.status    = STATUS_TRUNC;
               res.last      = 1'b1;
               phase_in      = PH_CHAN;
            end else begin
               res.valid     = 1'b1;
               res.channel   = channel_ff;
               res.type_code = cur_code;
               res.component = comp_ff;
               res.raw_value = extend_value(acc_shift, cur_len,
                                            comp_signed(cur_code, cur_len));
               res.status    = STATUS_VALUE;
               res.last      = end_of_packet;
               acc_in        = '0;
               if (record_done) begin
                  phase_in = PH_CHAN;
                  comp_in  = 2'd0;
               end else begin
                  comp_in       = comp_next[1:0];
                  bytes_left_in = comp_len(type_index_ff, comp_next[1:0]);
               end
            end
         end
         PH_DROP: begin
            if (end_of_packet) begin
               phase_in = PH_CHAN;
            end
         end
         default: begin
            phase_in = PH_CHAN;
         end
      endcase
      result       = res;
      result.valid = res.valid & fire;
   end

   // State advances once per consumed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_CHAN;
         channel_ff    <= '0;
         type_index_ff <= '0;
         comp_ff       <= '0;
         bytes_left_ff <= '0;
         acc_ff        <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         channel_ff    <= channel_in;
         type_index_ff <= type_index_in;
         comp_ff       <= comp_in;
         bytes_left_ff <= bytes_left_in;
         acc_ff        <= acc_in;
      end
   end

endmodule
`default_nettype wire

[design/lpp_record_stream_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpp_record_stream_parser
// Parses a byte stream of LPP records into raw value components.
// ----------------------------------------------------------------------------
// The parser takes one packet byte per request, tlast marking the packet's
// final byte, and returns at most one result per byte: a finished value
// component, an unknown-type report, or a flag for a packet that ended
// inside a record. It sustains one byte per clock cycle while the result side
// is not stalled. A byte's result passes through the input register and then
// the result register: the type table lookup and the parse state update
// settle between the two. The input side keeps accepting while a result waits
// on the output, until both registers are full.
module lpp_record_stream_parser
   import lpp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [55:0] rsp_tdata,   // [7:0] channel, [15:8] type_code,
                                         // [17:16] component, [50:18] raw_value
   output      logic [1:0]  rsp_tuser,   // [1:0] status
   output      logic        rsp_tlast
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   lpp_result_type rsp_ff;
   lpp_result_type result;
   logic           out_adv;
   logic           fire;

   // Handshake between the two register stages.
   assign out_adv    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_adv;
   assign req_tready = !in_valid_ff || out_adv;

   lpp_parse_core u_parse_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .data_byte     (in_byte_ff),
      .end_of_packet (in_last_ff),
      .result        (result)
   );

   // Input request register.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Result register.
   assign rsp_valid_in = out_adv ? result.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff.raw_value, rsp_ff.component,
                        rsp_ff.type_code, rsp_ff.channel};
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last;

endmodule
`default_nettype wire

[design/lpp_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpp_checker
// Port-level checks on the LPP record stream parser's result channel.
// ----------------------------------------------------------------------------
module lpp_checker
   import lpp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // A stalled result holds its payload.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_tvalid && !rsp_tready) |=>
            (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast));
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("stalled result changed");

   // No result is pending right after reset.
   property p_reset_clear;
      @(posedge clock) reset |=> !rsp_tvalid;
   endproperty
   a_reset_clear: assert property (p_reset_clear) else $error("result valid after reset");

   // Error reports carry a zero value.
   property p_error_zero;
      @(posedge clock) disable iff (reset)
         (rsp_tvalid && rsp_tuser != STATUS_VALUE) |-> (rsp_tdata[50:18] == 33'd0);
   endproperty
   a_error_zero: assert property (p_error_zero) else $error("error result with value");

   // A truncated record always ends the packet.
   property p_trunc_last;
      @(posedge clock) disable iff (reset)
         (rsp_tvalid && rsp_tuser == STATUS_TRUNC) |-> rsp_tlast;
   endproperty
   a_trunc_last: assert property (p_trunc_last) else $error("truncation without tlast");

   // Component numbers stop at two.
   property p_component_range;
      @(posedge clock) disable iff (reset)
         rsp_tvalid |-> (rsp_tdata[17:16] != 2'd3);
   endproperty
   a_component_range: assert property (p_component_range)
      else $error("component out of range");

endmodule

bind lpp_record_stream_parser lpp_checker u_lpp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LPP record stream parser. A short table of
// hand-written packets covers the value extremes, unknown types and packets
// cut off before a component is complete. Random packets of well-formed
// records with random content follow, mixed with unknown types and packets
// cut short. The idle and stall patterns on both sides change from phase to
// phase. Every accepted byte goes through a behavioral parser that predicts
// the results, and each result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
   import lpp_pkg::*;

   // One predicted or observed parser result.
   typedef struct packed {
      logic [7:0]     channel;
      logic [7:0]     type_code;
      logic [1:0]     component;
      logic [32:0]    raw_value;
      lpp_status_type status;
      logic           last;
   } lpp_component_type;

   // One row of the directed table; want is used only when typed is set.
   typedef struct packed {
      logic [7:0]        data;
      logic              last;
      logic              typed;
      lpp_component_type want;
   } directed_row_type;

   // Parse position of the behavioral parser.
   typedef enum logic [1:0] {
      WAIT_CHANNEL,
      WAIT_TYPE,
      IN_VALUE,
      SKIP_PACKET
   } parse_phase_type;

   localparam lpp_component_type UNTYPED = '0;
   localparam int NUM_CODES = 38;
   localparam int BYTES_PER_PHASE = 400;
   localparam int NUM_PHASES = 4;

   // Known type codes and the total value length of each.
   localparam logic [7:0] KNOWN_CODES [NUM_CODES] = '{
      8'd0,   8'd1,   8'd2,   8'd3,   8'd100, 8'd101, 8'd102, 8'd103,
      8'd104, 8'd112, 8'd113, 8'd115, 8'd116, 8'd117, 8'd118, 8'd120,
      8'd121, 8'd125, 8'd128, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134,
      8'd135, 8'd136, 8'd137, 8'd138, 8'd142, 8'd188, 8'd190, 8'd191,
      8'd192, 8'd193, 8'd194, 8'd195, 8'd203, 8'd255};
   localparam logic [3:0] KNOWN_LENGTHS [NUM_CODES] = '{
      4'd1, 4'd1, 4'd2, 4'd2, 4'd4, 4'd2, 4'd1, 4'd2,
      4'd1, 4'd2, 4'd6, 4'd2, 4'd2, 4'd2, 4'd4, 4'd1,
      4'd2, 4'd2, 4'd2, 4'd4, 4'd4, 4'd2, 4'd4, 4'd6,
      4'd3, 4'd9, 4'd11, 4'd2, 4'd1, 4'd2, 4'd2, 4'd2,
      4'd2, 4'd2, 4'd2, 4'd2, 4'd1, 4'd4};

   // Idle percentages of sender and receiver in each random phase.
   localparam int SENDER_IDLE [NUM_PHASES]    = '{0, 60, 0, 20};
   localparam int RECEIVER_STALL [NUM_PHASES] = '{0, 0, 60, 20};

   // Directed packets: channel byte alone, value extremes, unknown types and
   // packets that end inside a record.
   directed_row_type directed_rows [26] = '{
      '{8'hFF, 1'b1, 1'b1, '{8'hFF, 8'h00, 2'd0, 33'h0, STATUS_TRUNC, 1'b1}},
      '{8'h00, 1'b0, 1'b0, UNTYPED},
      '{8'h00, 1'b0, 1'b0, UNTYPED},
      '{8'hFF, 1'b1, 1'b1, '{8'h00, 8'h00, 2'd0, 33'h0_0000_00FF, STATUS_VALUE, 1'b1}},
      '{8'h01, 1'b0, 1'b0, UNTYPED},
      '{8'h71, 1'b0, 1'b0, UNTYPED},
      '{8'h80, 1'b0, 1'b0, UNTYPED},
      '{8'h00, 1'b0, 1'b1, '{8'h01, 8'h71, 2'd0, 33'h1_FFFF_8000, STATUS_VALUE, 1'b0}},
      '{8'h7F, 1'b0, 1'b0, UNTYPED},
      '{8'hFF, 1'b0, 1'b1, '{8'h01, 8'h71, 2'd1, 33'h0_0000_7FFF, STATUS_VALUE, 1'b0}},
      '{8'hFF, 1'b0, 1'b0, UNTYPED},
      '{8'hFF, 1'b1, 1'b1, '{8'h01, 8'h71, 2'd2, 33'h1_FFFF_FFFF, STATUS_VALUE, 1'b1}},
      '{8'h05, 1'b0, 1'b0, UNTYPED},
      '{8'h04, 1'b0, 1'b1, '{8'h05, 8'h04, 2'd0, 33'h0, STATUS_UNKNOWN, 1'b0}},
      '{8'h00, 1'b0, 1'b0, UNTYPED},
      '{8'h55, 1'b1, 1'b0, UNTYPED},
      '{8'h06, 1'b0, 1'b0, UNTYPED},
      '{8'hFE, 1'b1, 1'b1, '{8'h06, 8'hFE, 2'd0, 33'h0, STATUS_UNKNOWN, 1'b1}},
      '{8'h07, 1'b0, 1'b0, UNTYPED},
      '{8'h88, 1'b1, 1'b1, '{8'h07, 8'h88, 2'd0, 33'h0, STATUS_TRUNC, 1'b1}},
      '{8'h08, 1'b0, 1'b0, UNTYPED},
      '{8'h87, 1'b0, 1'b0, UNTYPED},
      '{8'h12, 1'b1, 1'b1, '{8'h08, 8'h87, 2'd0, 33'h0, STATUS_TRUNC, 1'b1}},
      '{8'h09, 1'b0, 1'b0, UNTYPED},
      '{8'hFF, 1'b0, 1'b0, UNTYPED},
      '{8'hAB, 1'b1, 1'b1, '{8'h09, 8'hFF, 2'd0, 33'h0, STATUS_TRUNC, 1'b1}}};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;           // [7:0] channel, [15:8] type_code,
                                     // [17:16] component, [50:18] raw_value
   logic [1:0]  rsp_tuser;           // [1:0] status
   logic        rsp_tlast;

   // Behavioral parser state.
   parse_phase_type parse_phase = WAIT_CHANNEL;
   logic [7:0]      rec_channel = 8'h00;
   logic [7:0]      rec_type = 8'h00;
   logic [3:0]      rec_table_len = 4'd0;
   logic [1:0]      comp_idx = 2'd0;
   logic [2:0]      bytes_missing = 3'd0;
   logic [31:0]     assembly = 32'h0;

   lpp_component_type expected_results [$];
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int failures = 0;
   int bytes_counted = 0;
   int packets_sent = 0;
   int values_seen = 0;
   int unknown_seen = 0;
   int trunc_seen = 0;

   lpp_record_stream_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Look a type code up in the table; returns 1 if it is known.
   function automatic logic find_code(input logic [7:0] code, output logic [3:0] total_len);
      logic found;
      found = 1'b0;
      total_len = 4'd0;
      for (int i = 0; i < NUM_CODES; i++) begin
         if (KNOWN_CODES[i] == code) begin
            found = 1'b1;
            total_len = KNOWN_LENGTHS[i];
         end
      end
      return found;
   endfunction

   // Byte length, signedness and component count of one component.
   function automatic void component_shape(input logic [7:0] code, input int comp,
                                           input logic [3:0] table_len, output int len,
                                           output logic sgn, output int count);
      case (code)
         T_ACCEL, T_GYRO: begin
            len = 2;
            sgn = 1'b1;
            count = 3;
         end
         T_GPS4: begin
            len = 3;
            sgn = 1'b1;
            count = 3;
         end
         T_GPS6: begin
            len = (comp < 2) ? 4 : 3;
            sgn = 1'b1;
            count = 3;
         end
         T_COLOUR: begin
            len = 1;
            sgn = 1'b0;
            count = 3;
         end
         T_NODE: begin
            len = int'(table_len);
            sgn = 1'b0;
            count = 1;
         end
         default: begin
            len = int'(table_len);
            sgn = (table_len == 4'd4);
            count = 1;
         end
      endcase
   endfunction

   // Keep the low len bytes of the assembly word, extended to 33 bits.
   function automatic logic [32:0] widen(input logic [31:0] word, input int len,
                                         input logic sgn);
      logic [32:0] mask;
      logic [32:0] v;
      mask = (33'd1 << (len * 8)) - 33'd1;
      v = {1'b0, word} & mask;
      if (sgn && v[len * 8 - 1]) begin
         v = v | ~mask;
      end
      return v;
   endfunction

   // Advance the behavioral parser by one byte; returns 1 with a result.
   function automatic logic predict_byte(input logic [7:0] b, input logic eop,
                                         output lpp_component_type r);
      logic       hit;
      logic       known;
      logic [3:0] tlen;
      int         len;
      logic       sgn;
      int         count;
      hit = 1'b0;
      r = '0;
      case (parse_phase)
         WAIT_CHANNEL: begin
            if (eop) begin
               r = '{b, 8'h00, 2'd0, 33'h0, STATUS_TRUNC, 1'b1};
               hit = 1'b1;
            end else begin
               rec_channel = b;
               parse_phase = WAIT_TYPE;
            end
         end
         WAIT_TYPE: begin
            known = find_code(b, tlen);
            if (!known) begin
               // Unknown type: report it and skip the rest of the packet.
               r = '{rec_channel, b, 2'd0, 33'h0, STATUS_UNKNOWN, eop};
               hit = 1'b1;
               parse_phase = eop ? WAIT_CHANNEL : SKIP_PACKET;
            end else begin
               rec_type = b;
               rec_table_len = tlen;
               comp_idx = 2'd0;
               assembly = 32'h0;
               component_shape(b, 0, tlen, len, sgn, count);
               bytes_missing = len[2:0];
               if (eop) begin
                  r = '{rec_channel, b, 2'd0, 33'h0, STATUS_TRUNC, 1'b1};
                  hit = 1'b1;
                  parse_phase = WAIT_CHANNEL;
               end else begin
                  parse_phase = IN_VALUE;
               end
            end
         end
         IN_VALUE: begin
            component_shape(rec_type, int'(comp_idx), rec_table_len, len, sgn, count);
            assembly = {assembly[23:0], b};
            if (bytes_missing != 3'd0) begin
               bytes_missing = bytes_missing - 3'd1;
            end
            if (bytes_missing != 3'd0) begin
               // Component still incomplete.
               if (eop) begin
                  r = '{rec_channel, rec_type, comp_idx, 33'h0, STATUS_TRUNC, 1'b1};
                  hit = 1'b1;
                  parse_phase = WAIT_CHANNEL;
               end
            end else if (eop && int'(comp_idx) + 1 < count) begin
               // Component done but the record is not; the packet end wins.
               r = '{rec_channel, rec_type, comp_idx, 33'h0, STATUS_TRUNC, 1'b1};
               hit = 1'b1;
               parse_phase = WAIT_CHANNEL;
            end else begin
               r = '{rec_channel, rec_type, comp_idx, widen(assembly, len, sgn),
                     STATUS_VALUE, eop};
               hit = 1'b1;
               assembly = 32'h0;
               if (int'(comp_idx) + 1 >= count) begin
                  parse_phase = WAIT_CHANNEL;
                  comp_idx = 2'd0;
               end else begin
                  comp_idx = comp_idx + 2'd1;
                  component_shape(rec_type, int'(comp_idx), rec_table_len, len, sgn,
                                  count);
                  bytes_missing = len[2:0];
               end
            end
         end
         default: begin
            if (eop) begin
               parse_phase = WAIT_CHANNEL;
            end
         end
      endcase
      return hit;
   endfunction

   // Present one byte, wait for its request to be taken, then predict.
   task automatic send_byte(input logic [7:0] b, input logic eop, input logic typed,
                            input lpp_component_type want);
      lpp_component_type predicted;
      logic              hit;
      logic              skipped;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= eop;
      do begin
         @(posedge clock);
      end while (!req_tready);
      skipped = (parse_phase == SKIP_PACKET);
      hit = predict_byte(b, eop, predicted);
      if (typed) begin
         expected_results.push_back(want);
      end else if (hit) begin
         expected_results.push_back(predicted);
      end
      if (!skipped) begin
         bytes_counted++;
      end
   endtask

   // Value bytes lean toward the sign and range boundaries.
   function automatic logic [7:0] value_byte();
      logic [7:0] v;
      case ($urandom_range(7))
         0: v = 8'h00;
         1: v = 8'hFF;
         2: v = 8'h80;
         3: v = 8'h7F;
         default: v = 8'($urandom_range(255));
      endcase
      return v;
   endfunction

   // Build a packet of records, sometimes with an unknown type or cut short.
   task automatic send_random_packet();
      logic [7:0] packet [$];
      logic [3:0] tlen;
      logic [7:0] code;
      int         num_records;
      int         idx;
      int         cut;
      num_records = $urandom_range(1, 4);
      for (int r = 0; r < num_records; r++) begin
         packet.push_back(8'($urandom_range(255)));
         if ($urandom_range(99) < 8) begin
            // Unknown type followed by up to three bytes that must be skipped.
            do begin
               code = 8'($urandom_range(255));
            end while (find_code(code, tlen));
            packet.push_back(code);
            for (int j = $urandom_range(3); j > 0; j--) begin
               packet.push_back(8'($urandom_range(255)));
            end
            break;
         end
         idx = $urandom_range(NUM_CODES - 1);
         packet.push_back(KNOWN_CODES[idx]);
         for (int j = 0; j < int'(KNOWN_LENGTHS[idx]); j++) begin
            packet.push_back(value_byte());
         end
      end
      // Now and then the packet ends early, anywhere inside it.
      if ($urandom_range(99) < 12) begin
         cut = $urandom_range(packet.size() - 1);
         while (packet.size() > cut + 1) begin
            void'(packet.pop_back());
         end
      end
      for (int j = 0; j < packet.size(); j++) begin
         send_byte(packet[j], j == packet.size() - 1, 1'b0, UNTYPED);
      end
      packets_sent++;
   endtask

   // Compare one field and log any difference.
   task automatic check_field(input string name, input logic [32:0] want,
                              input logic [32:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         failures++;
      end
   endtask

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Check each result against the oldest expectation.
   always @(posedge clock) begin : result_check
      lpp_component_type got;
      lpp_component_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[17:16], rsp_tdata[50:18],
                 lpp_status_type'(rsp_tuser), rsp_tlast};
         if (expected_results.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual %0h",
                     $time, got);
            failures++;
         end else begin
            want = expected_results.pop_front();
            check_field("channel", 33'(want.channel), 33'(got.channel));
            check_field("type_code", 33'(want.type_code), 33'(got.type_code));
            check_field("component", 33'(want.component), 33'(got.component));
            check_field("raw_value", want.raw_value, got.raw_value);
            check_field("status", 33'(want.status), 33'(got.status));
            check_field("packet_last", 33'(want.last), 33'(got.last));
            case (want.status)
               STATUS_VALUE: values_seen++;
               STATUS_UNKNOWN: unknown_seen++;
               default: trunc_seen++;
            endcase
         end
      end
   end

   // Stimulus: directed table, then random packets under each idle pattern.
   initial begin : stimulus
      $timeformat(-9, 1, " ns", 10);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < $size(directed_rows); i++) begin
         send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                   directed_rows[i].want);
      end
      for (int p = 0; p < NUM_PHASES; p++) begin
         sender_idle_pct = SENDER_IDLE[p];
         receiver_stall_pct = RECEIVER_STALL[p];
         while (bytes_counted < $size(directed_rows) + BYTES_PER_PHASE * (p + 1)) begin
            send_random_packet();
         end
      end
      req_tvalid <= 1'b0;

      // Drain outstanding results, then give stray results time to show up.
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      $display("Sent %0d parsed bytes: the directed table plus %0d random packets.",
               bytes_counted, packets_sent);
      $display("Checked %0d values, %0d unknown types, %0d truncated packets; %0d errors.",
               values_seen, unknown_seen, trunc_seen, failures);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("Timeout with %0d results outstanding.", expected_results.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
